// ===== src/rlc_pkg.sv =====
// Package for the row line centroid block: widths, row totals type, register
// indexes and the back-end state type. Used by every module in src.
`timescale 1ns / 1ps

package rlc_pkg;

  localparam int SUM_W   = 20;   // signed sum of column offsets
  localparam int CNT_W   = 10;   // white pixel count, also column width
  localparam int ERR_W   = 10;   // signed line error
  localparam int THR_W   = 8;
  localparam int CTR_W   = 9;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 9;
  localparam int IDX_W   = 1;
  localparam int OFS_W   = CNT_W + 1;
  localparam int DCNT_W  = $clog2(SUM_W);

  localparam logic [IDX_W-1:0] REG_THRESH = 1'b0;
  localparam logic [IDX_W-1:0] REG_CENTER = 1'b1;

  localparam logic [THR_W-1:0] THRESH_RST = 8'd127;
  localparam logic [CTR_W-1:0] CENTER_RST = 9'd160;

  // Totals of one finished row, handed from the front to the divider.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } row_tot_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

// ===== src/row_line_centroid_error.sv =====
// From the beat carrying row_end, the row totals pass the queue, the divider
// load and a restoring divide to the result beat; a row without white pixels
// skips the divide. One pixel per cycle while in_stall is low; the two-row
// queue absorbs short rows, and in_stall rises while it is full.
// Reset (rst_n low, synchronous) clears the row totals and the queue, returns
// the divider to idle, and loads threshold 127 and center 160.
`timescale 1ns / 1ps

module row_line_centroid_error #(
  parameter int COLUMNS = 320
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rlc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rlc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rlc_pkg::PIX_W-1:0]         in_pixel_level,
  input  logic                              in_row_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rlc_pkg::ERR_W-1:0]  out_line_error,
  output logic [rlc_pkg::CNT_W-1:0]         out_white_count,
  output logic                              out_no_line
);

  logic              push;
  logic              pop;
  rlc_pkg::row_tot_t push_data;
  rlc_pkg::row_tot_t head;
  rlc_pkg::q_stat_t  q_stat;

  rlc_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_level (in_pixel_level),
    .in_row_end     (in_row_end),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  rlc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  rlc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_error  (out_line_error),
    .out_white_count (out_white_count),
    .out_no_line     (out_no_line)
  );

endmodule

// ===== src/rlc_front.sv =====
// Front end: configuration registers, pixel classification and row
// accumulation. Depends on rlc_pkg; pushes finished rows into rlc_queue.
`timescale 1ns / 1ps

module rlc_front #(
  parameter int COLUMNS = 320
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rlc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rlc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rlc_pkg::PIX_W-1:0]   in_pixel_level,
  input  logic                        in_row_end,
  input  rlc_pkg::q_stat_t            q_stat,
  output logic                        push,
  output rlc_pkg::row_tot_t           push_data
);

  localparam int CIDX_W = $clog2(COLUMNS + 1);

  logic [rlc_pkg::THR_W-1:0]        thr_r;
  logic [rlc_pkg::CTR_W-1:0]        ctr_r;
  logic [CIDX_W-1:0]                col_r, col_nxt;
  logic signed [rlc_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [rlc_pkg::CNT_W-1:0]        tally_r, tally_nxt;

  logic                             accept;
  logic                             in_range;
  logic                             white;
  logic signed [rlc_pkg::OFS_W-1:0] offset;

  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~in_stall;
  assign in_range = col_r < CIDX_W'(COLUMNS);
  assign white    = in_pixel_level > thr_r;
  assign offset   = signed'({1'b0, rlc_pkg::CNT_W'(col_r)})
                  - signed'({2'b00, ctr_r});

  always_comb begin
    col_nxt   = col_r;
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    if (in_range) begin
      col_nxt = col_r + 1'b1;
      if (white) begin
        sum_nxt   = sum_r + rlc_pkg::SUM_W'(offset);
        tally_nxt = tally_r + 1'b1;
      end
    end
  end

  assign push          = accept & in_row_end;
  assign push_data.sum = sum_nxt;
  assign push_data.cnt = tally_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rlc_pkg::THRESH_RST;
      ctr_r <= rlc_pkg::CENTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlc_pkg::REG_THRESH: thr_r <= cfg_data[rlc_pkg::THR_W-1:0];
        rlc_pkg::REG_CENTER: ctr_r <= cfg_data[rlc_pkg::CTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      sum_r   <= '0;
      tally_r <= '0;
    end else if (accept) begin
      if (in_row_end) begin
        col_r   <= '0;
        sum_r   <= '0;
        tally_r <= '0;
      end else begin
        col_r   <= col_nxt;
        sum_r   <= sum_nxt;
        tally_r <= tally_nxt;
      end
    end
  end

endmodule

// ===== src/rlc_queue.sv =====
// Two-entry queue of finished row totals between front and divider.
// Depends on rlc_pkg for the row totals type and status struct.
`timescale 1ns / 1ps

module rlc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rlc_pkg::row_tot_t push_data,
  input  logic              pop,
  output rlc_pkg::row_tot_t head,
  output rlc_pkg::q_stat_t  q_stat
);

  rlc_pkg::row_tot_t ent_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;

  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;
  assign head         = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/rlc_back.sv =====
// Back end: restoring divider (one quotient bit per cycle) and the output
// register. Depends on rlc_pkg; takes row totals from rlc_queue.
`timescale 1ns / 1ps

module rlc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rlc_pkg::row_tot_t                 head,
  input  rlc_pkg::q_stat_t                  q_stat,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rlc_pkg::ERR_W-1:0]  out_line_error,
  output logic [rlc_pkg::CNT_W-1:0]         out_white_count,
  output logic                              out_no_line
);

  localparam int SW = rlc_pkg::SUM_W;
  localparam int CW = rlc_pkg::CNT_W;

  rlc_pkg::back_state_t state_r, state_nxt;

  logic [SW-1:0]     quo_r;
  logic [CW-1:0]     rem_r;
  logic [CW-1:0]     div_r;
  logic              neg_r;
  logic [rlc_pkg::DCNT_W-1:0] step_r;
  logic              last_step;
  logic              zero_cnt;

  logic [CW:0]       shifted;
  logic [CW:0]       diff;
  logic              qbit;

  logic signed [rlc_pkg::ERR_W-1:0] err_r;
  logic [CW-1:0]                    cnt_out_r;
  logic                             none_r;
  logic [rlc_pkg::ERR_W-1:0]        qmag;

  assign zero_cnt  = head.cnt == '0;
  assign last_step = step_r == rlc_pkg::DCNT_W'(SW - 1);
  assign shifted   = {rem_r, quo_r[SW-1]};
  assign diff      = shifted - {1'b0, div_r};
  assign qbit      = ~diff[CW];
  assign qmag      = quo_r[rlc_pkg::ERR_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlc_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = zero_cnt ? rlc_pkg::BK_OUT : rlc_pkg::BK_DIV;
        end
      end
      rlc_pkg::BK_DIV: begin
        if (last_step) begin
          state_nxt = rlc_pkg::BK_OUT;
        end
      end
      rlc_pkg::BK_OUT: begin
        if (!out_stall) begin
          state_nxt = rlc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rlc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      rlc_pkg::BK_IDLE: pop = ~q_stat.empty;
      rlc_pkg::BK_DIV:  ;
      rlc_pkg::BK_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlc_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Divider datapath; the quotient magnitude is negated at the end when the
  // sum was negative, which gives truncation toward zero.
  always_ff @(posedge clk) begin
    if (state_r == rlc_pkg::BK_IDLE && !q_stat.empty) begin
      neg_r     <= head.sum[SW-1];
      quo_r     <= head.sum[SW-1] ? SW'(-head.sum) : SW'(head.sum);
      rem_r     <= '0;
      div_r     <= head.cnt;
      step_r    <= '0;
      cnt_out_r <= head.cnt;
      none_r    <= zero_cnt;
      err_r     <= '0;
    end else if (state_r == rlc_pkg::BK_DIV) begin
      rem_r  <= qbit ? diff[CW-1:0] : shifted[CW-1:0];
      quo_r  <= {quo_r[SW-2:0], qbit};
      step_r <= step_r + 1'b1;
      if (last_step) begin
        err_r <= neg_r ? -signed'({qmag[rlc_pkg::ERR_W-2:0], qbit})
                       :  signed'({qmag[rlc_pkg::ERR_W-2:0], qbit});
      end
    end
  end

  assign out_line_error  = err_r;
  assign out_white_count = cnt_out_r;
  assign out_no_line     = none_r;

`ifndef SYNTHESIS
  a_none_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_no_line == (out_white_count == '0)))
    else $error("no_line disagrees with white_count");

  a_none_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_line) |-> (out_line_error == '0))
    else $error("line_error nonzero on a row without a line");

  a_div_ends_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlc_pkg::BK_DIV && last_step) |=> (state_r == rlc_pkg::BK_OUT))
    else $error("divider did not hand its result to the output");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == rlc_pkg::BK_IDLE && !q_stat.empty))
    else $error("queue popped outside idle or while empty");
`endif

endmodule

// ===== test/row_centroid_checker.sv =====
// Watches the configuration port and both beat channels of row_line_centroid_error,
// tracks the row totals itself and compares every result beat with its prediction.
// Depends on rlc_pkg for widths and register indexes.
`timescale 1ns / 1ps

module row_centroid_checker
  import rlc_pkg::*;
#(
  parameter int COLUMNS = 320
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [PIX_W-1:0]        in_pixel_level,
  input  logic                    in_row_end,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [ERR_W-1:0] out_line_error,
  input  logic [CNT_W-1:0]        out_white_count,
  input  logic                    out_no_line,
  output int                      fail_count,
  output int                      rows_pending
);

  typedef struct packed {
    logic signed [ERR_W-1:0] line_error;
    logic [CNT_W-1:0]        white_count;
    logic                    no_line;
  } row_result_t;

  row_result_t expected_rows[$];

  logic [THR_W-1:0]        threshold;
  logic [CTR_W-1:0]        center;
  logic [CNT_W-1:0]        column;
  logic signed [SUM_W-1:0] offset_sum;
  logic [CNT_W-1:0]        white_tally;

  initial begin
    fail_count = 0;
    rows_pending = 0;
  end

  task automatic take_pixel(input logic [PIX_W-1:0] level, input logic last);
    row_result_t r;
    int quotient;
    // Pixels past the row width change nothing, but row_end still closes the row.
    if (int'(column) < COLUMNS) begin
      if (level > threshold) begin
        offset_sum = offset_sum + (int'(column) - int'(center));
        white_tally = white_tally + 1'b1;
      end
      column = column + 1'b1;
    end
    if (last) begin
      quotient = (white_tally == 0) ? 0 : int'(offset_sum) / int'(white_tally);
      r.line_error = quotient[ERR_W-1:0];
      r.white_count = white_tally;
      r.no_line = (white_tally == 0);
      expected_rows.push_back(r);
      column = '0;
      offset_sum = '0;
      white_tally = '0;
    end
  endtask

  task automatic check_result();
    row_result_t exp_r;
    if (expected_rows.size() == 0) begin
      $error("result beat arrived with no row pending");
      fail_count++;
    end else begin
      exp_r = expected_rows.pop_front();
      if (out_line_error !== exp_r.line_error) begin
        $error("line_error: expected %0d, got %0d", exp_r.line_error, out_line_error);
        fail_count++;
      end
      if (out_white_count !== exp_r.white_count) begin
        $error("white_count: expected %0d, got %0d", exp_r.white_count, out_white_count);
        fail_count++;
      end
      if (out_no_line !== exp_r.no_line) begin
        $error("no_line: expected %0d, got %0d", exp_r.no_line, out_no_line);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold = THRESH_RST;
      center = CENTER_RST;
      column = '0;
      offset_sum = '0;
      white_tally = '0;
      expected_rows.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESH: threshold = cfg_data[THR_W-1:0];
          REG_CENTER: center = cfg_data[CTR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_pixel(in_pixel_level, in_row_end);
    end
    rows_pending = expected_rows.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the row_line_centroid_error testbench: clock, reset, register writes,
// pixel rows and random output stalls. Prediction and checking live in
// row_centroid_checker; both depend on rlc_pkg.
`timescale 1ns / 1ps

module tb;
  import rlc_pkg::*;

  localparam int COLUMNS = 320;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASES = 6;
  localparam int PHASE_PIXELS = 160;

  typedef enum int {
    LV_RANDOM,
    LV_DARK,
    LV_BRIGHT,
    LV_EDGE,
    LV_EXTREME,
    LV_FULL
  } level_mix_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = REG_THRESH;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [PIX_W-1:0]        in_pixel_level = '0;
  logic                    in_row_end = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ERR_W-1:0] out_line_error;
  logic [CNT_W-1:0]        out_white_count;
  logic                    out_no_line;

  int fail_count;
  int rows_pending;
  int cycle_count = 0;
  int stall_left = 0;
  int cur_thresh = THRESH_RST;

  row_line_centroid_error #(.COLUMNS(COLUMNS)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_level(in_pixel_level), .in_row_end(in_row_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_line_error(out_line_error), .out_white_count(out_white_count),
    .out_no_line(out_no_line)
  );

  row_centroid_checker #(.COLUMNS(COLUMNS)) u_row_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_level(in_pixel_level), .in_row_end(in_row_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_line_error(out_line_error), .out_white_count(out_white_count),
    .out_no_line(out_no_line),
    .fail_count(fail_count), .rows_pending(rows_pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: runs of open cycles, short stalls and the odd long one.
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 20);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int pick_row_length();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return $urandom_range(COLUMNS - 4, COLUMNS + 20);
    if (r < 11) return $urandom_range(17, 64);
    return $urandom_range(1, 16);
  endfunction

  function automatic logic [PIX_W-1:0] pick_level(input level_mix_t mix);
    int v;
    case (mix)
      LV_DARK: v = $urandom_range(0, cur_thresh);
      LV_BRIGHT: v = ($urandom_range(0, 3) != 0) ? $urandom_range(cur_thresh, 255)
                                                  : $urandom_range(0, 255);
      LV_EDGE: begin
        v = cur_thresh + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      LV_EXTREME: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
      LV_FULL: v = 255;
      default: v = $urandom_range(0, 255);
    endcase
    return v[PIX_W-1:0];
  endfunction

  // Called on a clock edge; returns on the edge that accepts the beat.
  task automatic send_pixel(input logic [PIX_W-1:0] level, input logic last, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_level <= level;
    in_row_end <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_row(input int len, input level_mix_t mix);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++)
      send_pixel(pick_level(mix), i == len - 1, burst ? 0 : pick_gap());
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
  endtask

  // A row with no white pixel skips the divide, so give the block time to go quiet.
  task automatic drain();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input int thresh, input int center);
    cfg_we <= 1'b1;
    cfg_index <= REG_THRESH;
    cfg_data <= CFG_W'(thresh);
    @(posedge clk);
    cfg_index <= REG_CENTER;
    cfg_data <= CFG_W'(center);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_thresh = thresh;
  endtask

  initial begin
    int sent;
    int len;
    int thresh;
    int center;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: lone white pixel at the left edge, an empty row, a pixel
    // exactly at the threshold next to one just above it, and a mixed row.
    send_pixel(8'd255, 1'b1, pick_gap());
    send_pixel(8'd0, 1'b1, pick_gap());
    send_pixel(8'd127, 1'b0, pick_gap());
    send_pixel(8'd128, 1'b1, pick_gap());
    send_pixel(8'd255, 1'b0, 0);
    send_pixel(8'd0, 1'b0, 0);
    send_pixel(8'd255, 1'b0, 0);
    send_pixel(8'd0, 1'b0, 0);
    send_pixel(8'd255, 1'b1, 0);
    drain();
    // Lowest threshold, farthest center: a large negative error.
    apply_setting(0, 511);
    send_pixel(8'd1, 1'b0, pick_gap());
    send_pixel(8'd0, 1'b0, pick_gap());
    send_pixel(8'd1, 1'b1, pick_gap());
    send_pixel(8'd0, 1'b1, pick_gap());
    drain();
    // Odd negative sum: the quotient rounds toward zero, not down.
    apply_setting(0, 2);
    send_pixel(8'd9, 1'b0, 0);
    send_pixel(8'd200, 1'b1, 0);
    drain();
    apply_setting(0, 0);
    send_pixel(8'd0, 1'b0, 0);
    send_pixel(8'd77, 1'b0, 0);
    send_pixel(8'd78, 1'b1, 0);
    drain();
    // Highest threshold: nothing can be white.
    apply_setting(255, 0);
    send_pixel(8'd255, 1'b0, pick_gap());
    send_pixel(8'd255, 1'b1, pick_gap());

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin thresh = THRESH_RST; center = CENTER_RST; end
        1: begin thresh = 0; center = 0; end
        2: begin thresh = 255; center = 511; end
        3: begin thresh = $urandom_range(0, 255); center = $urandom_range(0, 511); end
        4: begin thresh = 1; center = COLUMNS - 1; end
        default: begin thresh = 254; center = $urandom_range(0, 511); end
      endcase
      apply_setting(thresh, center);
      sent = 0;
      if (p == 1) begin
        // Every column white and the row running past its width.
        send_row(COLUMNS + 9, LV_FULL);
        sent = COLUMNS + 9;
      end
      while (sent < PHASE_PIXELS) begin
        if ($urandom_range(0, 39) == 0) wait_results();
        len = pick_row_length();
        send_row(len, level_mix_t'($urandom_range(0, 5)));
        sent += len;
      end
    end

    drain();
    if (fail_count == 0 && rows_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
